// File: rtl/mrt_pkg.sv
// Shared types and constants for the modem response tokenizer.
// No dependencies; used by mrt_classify and modem_response_tokenizer_unit.

package mrt_pkg;

    // Capacity of the pending token byte store.
    localparam int TOKEN_STORE_BYTES = 512;
    localparam int COUNT_W           = $clog2(TOKEN_STORE_BYTES + 1);
    localparam int TOKEN_LEN_W       = 10;

    // Characters that mark token boundaries.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Bytes an echo or an SMS body leaves pending after it completes.
    localparam logic [COUNT_W-1:0] KEEP_ECHO = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] KEEP_SMS  = COUNT_W'(2);

    typedef enum logic [2:0] {
        KIND_ECHO    = 3'd0,
        KIND_RESP    = 3'd1,
        KIND_DATA    = 3'd2,
        KIND_SMSBODY = 3'd3,
        KIND_PROMPT  = 3'd4
    } token_kind_t;

    // Tokenizer state carried from one item to the next.
    typedef struct packed {
        logic [7:0]         previous_byte;
        logic               after_blank_crlf;
        logic               only_control_seen;
        logic               sms_prompt_open;
        logic [COUNT_W-1:0] pending_count;
    } tok_state_t;

    // Result of one item.
    typedef struct packed {
        logic                   token_ready;
        token_kind_t            token_kind;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic                   byte_dropped;
    } tok_result_t;

endpackage

// File: rtl/modem_response_tokenizer_unit.sv
// Modem response tokenizer: classifies token boundaries in a modem byte stream.
// Uses mrt_pkg for types and constants and instantiates mrt_classify.
//
// Usage:
//   The slave channel takes one received modem byte per item on s_axis_tdata.
//   For every byte the master channel gives exactly one result item: a
//   token-complete flag and the token kind on m_axis_tuser, and the token
//   length and a store-overflow flag on m_axis_tdata.
//   A byte waits in an input register; the classifier updates the
//   tokenizer state as the byte moves into the result register, which
//   then offers the result item.
//   Throughput is one item per cycle while the receiver does not stall: the state
//   update is a single pass of compares, flag logic, one add and one subtract between the two registers.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more byte; after that s_axis_tready
//   drops until the result is taken.
//   Reset (aresetn low at a clock edge) empties both registers, clears the
//   previous byte, the pending count and the CR LF and prompt flags, and
//   sets the only-control flag.

module modem_response_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] token_length, [10] byte_dropped, zero above
    output logic [3:0]  m_axis_tuser    // [0] token_ready, [3:1] token_kind
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    mrt_pkg::tok_result_t out_result_reg;
    mrt_pkg::tok_state_t  state_reg;
    mrt_pkg::tok_state_t  state_next;
    mrt_pkg::tok_result_t result_next;
    logic                 advance;

    // The held byte moves on when the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    mrt_classify u_classify (
        .rx_byte    (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Tokenizer state, updated once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.previous_byte     <= '0;
            state_reg.after_blank_crlf  <= 1'b0;
            state_reg.only_control_seen <= 1'b1;
            state_reg.sms_prompt_open   <= 1'b0;
            state_reg.pending_count     <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_result_reg.token_kind, out_result_reg.token_ready};
    assign m_axis_tdata  = {5'b0, out_result_reg.byte_dropped, out_result_reg.token_length};

endmodule

// File: rtl/mrt_classify.sv
// Combinational classifier: next tokenizer state and result for one byte.
// Depends on mrt_pkg for the state and result types.

module mrt_classify (
    input  logic [7:0]          rx_byte,
    input  mrt_pkg::tok_state_t state_cur,
    output mrt_pkg::tok_state_t state_next,
    output mrt_pkg::tok_result_t result
);

    logic                        store_full;
    logic [mrt_pkg::COUNT_W-1:0] count_in;
    logic                        is_control;
    logic                        ocs;
    logic                        prev_cr;
    logic                        crlf;
    logic                        ready;
    mrt_pkg::token_kind_t        kind;
    logic [mrt_pkg::COUNT_W-1:0] keep;
    logic                        long_enough;

    // Count the byte into the pending store unless it is already full.
    assign store_full = (state_cur.pending_count >=
                         mrt_pkg::COUNT_W'(mrt_pkg::TOKEN_STORE_BYTES));
    assign count_in   = store_full ? state_cur.pending_count
                                   : state_cur.pending_count + mrt_pkg::COUNT_W'(1);

    // A byte that is not a control code (below 20h or DEL) clears the only-control flag before the rules apply.
    assign is_control = (rx_byte < 8'h20) || (rx_byte == mrt_pkg::CH_DEL);
    assign ocs        = state_cur.only_control_seen & is_control;

    assign prev_cr = (state_cur.previous_byte == mrt_pkg::CH_CR);
    assign crlf    = prev_cr && (rx_byte == mrt_pkg::CH_LF);

    // Token rules; the first match wins.
    always_comb begin
        ready = 1'b1;
        kind  = mrt_pkg::KIND_ECHO;
        priority if (prev_cr && !crlf && !state_cur.after_blank_crlf && !ocs) begin
            kind = mrt_pkg::KIND_ECHO;
        end else if (crlf && state_cur.after_blank_crlf) begin
            kind = mrt_pkg::KIND_RESP;
        end else if (crlf && !ocs && !state_cur.sms_prompt_open) begin
            kind = mrt_pkg::KIND_DATA;
        end else if (crlf && !ocs) begin
            kind = mrt_pkg::KIND_SMSBODY;
        end else if ((state_cur.previous_byte == mrt_pkg::CH_GT) &&
                     (rx_byte == mrt_pkg::CH_SP) && state_cur.after_blank_crlf) begin
            kind = mrt_pkg::KIND_PROMPT;
        end else begin
            ready = 1'b0;
        end
    end

    // Bytes that stay pending after the token.
    always_comb begin
        unique case (kind)
            mrt_pkg::KIND_ECHO:    keep = mrt_pkg::KEEP_ECHO;
            mrt_pkg::KIND_SMSBODY: keep = mrt_pkg::KEEP_SMS;
            default:               keep = '0;
        endcase
    end

    assign long_enough = (count_in > keep);

    // Result fields.
    always_comb begin
        result.token_ready  = ready;
        result.token_kind   = ready ? kind : mrt_pkg::KIND_ECHO;
        result.byte_dropped = store_full;
        if (ready && long_enough) begin
            result.token_length = mrt_pkg::TOKEN_LEN_W'(count_in - keep);
        end else begin
            result.token_length = '0;
        end
    end

    // Next state.
    always_comb begin
        state_next.previous_byte     = rx_byte;
        state_next.after_blank_crlf  = state_cur.after_blank_crlf;
        state_next.only_control_seen = ocs;
        state_next.sms_prompt_open   = state_cur.sms_prompt_open;
        state_next.pending_count     = count_in;
        if (ready) begin
            state_next.sms_prompt_open   = (kind == mrt_pkg::KIND_PROMPT);
            state_next.after_blank_crlf  = (kind == mrt_pkg::KIND_SMSBODY);
            state_next.only_control_seen = 1'b1;
            if (long_enough) begin
                state_next.pending_count = keep;
            end
        end else if (crlf && !state_cur.after_blank_crlf && ocs) begin
            // A blank CR LF opens the way for a response or a prompt.
            state_next.after_blank_crlf = 1'b1;
        end
    end

endmodule

// File: bench/modem_response_tokenizer_unit_test.sv
// Self-checking testbench for modem_response_tokenizer_unit.
// Depends on mrt_pkg and the tokenizer RTL; the predictor is a model of its own.

module modem_response_tokenizer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 135;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;           // [9:0] token_length, [10] byte_dropped
    logic [3:0]  m_axis_tuser;           // [0] token_ready, [3:1] token_kind

    // Predicted tokenizer state.
    logic [7:0]                  last_rx;
    logic                        crlf_blank;
    logic                        ctrl_only;
    logic                        prompt_open;
    logic [mrt_pkg::COUNT_W-1:0] pending_bytes;

    mrt_pkg::tok_result_t expected_tokens[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    modem_response_tokenizer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 aclk = ~aclk;

    // Works out the result of one received byte and advances the predicted state.
    function automatic mrt_pkg::tok_result_t tokenize_byte(input logic [7:0] c);
        mrt_pkg::tok_result_t        res;
        logic [mrt_pkg::COUNT_W-1:0] keep;
        logic                        hit;
        res  = '0;
        keep = '0;
        hit  = 1'b1;
        if (pending_bytes >= mrt_pkg::COUNT_W'(mrt_pkg::TOKEN_STORE_BYTES)) begin
            res.byte_dropped = 1'b1;
        end else begin
            pending_bytes = pending_bytes + mrt_pkg::COUNT_W'(1);
        end
        if (!(c < mrt_pkg::CH_SP || c == mrt_pkg::CH_DEL)) begin
            ctrl_only = 1'b0;
        end

        // The first matching boundary rule decides the token kind.
        if (last_rx == mrt_pkg::CH_CR && c != mrt_pkg::CH_LF && !crlf_blank && !ctrl_only) begin
            res.token_kind = mrt_pkg::KIND_ECHO;
        end else if (last_rx == mrt_pkg::CH_CR && c == mrt_pkg::CH_LF && crlf_blank) begin
            res.token_kind = mrt_pkg::KIND_RESP;
        end else if (last_rx == mrt_pkg::CH_CR && c == mrt_pkg::CH_LF && !ctrl_only) begin
            res.token_kind = prompt_open ? mrt_pkg::KIND_SMSBODY : mrt_pkg::KIND_DATA;
        end else if (last_rx == mrt_pkg::CH_GT && c == mrt_pkg::CH_SP && crlf_blank) begin
            res.token_kind = mrt_pkg::KIND_PROMPT;
        end else begin
            hit = 1'b0;
        end

        if (hit) begin
            res.token_ready = 1'b1;
            if (res.token_kind == mrt_pkg::KIND_ECHO) begin
                keep = mrt_pkg::KEEP_ECHO;
            end else if (res.token_kind == mrt_pkg::KIND_SMSBODY) begin
                keep = mrt_pkg::KEEP_SMS;
            end
            prompt_open = (res.token_kind == mrt_pkg::KIND_PROMPT);
            crlf_blank  = (res.token_kind == mrt_pkg::KIND_SMSBODY);
            ctrl_only   = 1'b1;
            // A token with no more pending bytes than it keeps takes nothing from the store.
            if (pending_bytes > keep) begin
                res.token_length = mrt_pkg::TOKEN_LEN_W'(pending_bytes - keep);
                pending_bytes    = keep;
            end
        end else if (last_rx == mrt_pkg::CH_CR && c == mrt_pkg::CH_LF && !crlf_blank
                     && ctrl_only) begin
            // A CR LF with only control bytes before it opens the way for a response or a prompt.
            crlf_blank = 1'b1;
        end
        last_rx = c;
        return res;
    endfunction

    // Mostly printable characters, now and then any byte value.
    function automatic logic [7:0] reply_char();
        if ($urandom_range(0, 99) < 85) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one byte to the block and records its expected result once accepted.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        expected_tokens.push_back(tokenize_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_crlf();
        send_byte(mrt_pkg::CH_CR);
        send_byte(mrt_pkg::CH_LF);
    endtask

    task automatic send_random_text(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(reply_char());
        end
    endtask

    // Receiver readiness changes at the falling edge.
    always @(negedge aclk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker and stall watchdog.
    always @(posedge aclk) begin
        mrt_pkg::tok_result_t want;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("modem_response_tokenizer_unit regression: fail");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected result item: tuser=%h tdata=%h",
                                 m_axis_tuser, m_axis_tdata);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_axis_tuser[0] !== want.token_ready
                            || m_axis_tuser[3:1] !== want.token_kind
                            || m_axis_tdata[9:0] !== want.token_length
                            || m_axis_tdata[10] !== want.byte_dropped) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("mismatch: expected ready=%0d kind=%0d len=%0d drop=%0d",
                                     want.token_ready, want.token_kind,
                                     want.token_length, want.byte_dropped);
                            $display("          actual   ready=%0d kind=%0d len=%0d drop=%0d",
                                     m_axis_tuser[0], m_axis_tuser[3:1],
                                     m_axis_tdata[9:0], m_axis_tdata[10]);
                        end
                    end
                end
            end
        end
    end

    // Extreme and control byte values before any carriage return.
    task automatic test_byte_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mrt_pkg::CH_DEL);
        send_byte(8'h80);
        send_byte(8'h1F);
        send_byte(8'h55);
        send_byte(8'hAA);
    endtask

    // One of each token kind plus a blank CR LF, in a realistic SMS exchange.
    task automatic test_token_kinds();
        send_text("AT");
        send_byte(mrt_pkg::CH_CR);      // the next byte closes the echo
        send_crlf();           // blank line before the response
        send_text("OK");
        send_crlf();           // response
        send_crlf();
        send_text("> ");       // SMS prompt
        send_text("hi");
        send_crlf();           // SMS body
        send_crlf();           // response after the body
        send_text("+X");
        send_crlf();           // data block
    endtask

    // More bytes than the store holds; the surplus is dropped.
    task automatic test_store_saturation();
        for (int i = 0; i < mrt_pkg::TOKEN_STORE_BYTES + 8; i++) begin
            send_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
        send_crlf();
        send_text("ok");
        send_crlf();
    endtask

    // Random replies, mostly well formed, some noise and broken fragments.
    task automatic test_random_replies(input int n);
        int stop_at;
        int pick;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_text("AT");
                send_random_text($urandom_range(0, 6));
                send_byte(mrt_pkg::CH_CR);
            end else if (pick < 35) begin
                send_crlf();
                send_random_text($urandom_range(1, 8));
                send_crlf();
            end else if (pick < 45) begin
                send_crlf();
                send_text("> ");
                send_random_text($urandom_range(0, 10));
                send_crlf();
            end else if (pick < 58) begin
                send_random_text($urandom_range(1, 12));
                send_crlf();
            end else if (pick < 66) begin
                send_crlf();
            end else if (pick < 80) begin
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end else if (pick < 97) begin
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    case ($urandom_range(0, 3))
                        0: send_byte(mrt_pkg::CH_CR);
                        1: send_byte(mrt_pkg::CH_LF);
                        2: send_byte(mrt_pkg::CH_GT);
                        default: send_byte(mrt_pkg::CH_SP);
                    endcase
                end
            end else begin
                send_random_text($urandom_range(40, 80));
            end
        end
    endtask

    task automatic set_pressure(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        last_rx       = 8'h00;
        crlf_blank    = 1'b0;
        ctrl_only     = 1'b1;
        prompt_open   = 1'b0;
        pending_bytes = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_byte_extremes();
        test_token_kinds();
        set_pressure(48, 48);
        test_store_saturation();

        set_pressure(0, 0);
        test_random_replies(RANDOM_ITEMS);
        set_pressure(48, 0);
        test_random_replies(RANDOM_ITEMS);
        set_pressure(0, 48);
        test_random_replies(RANDOM_ITEMS);
        set_pressure(20, 20);
        test_random_replies(RANDOM_ITEMS);

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (expected_tokens.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("modem_response_tokenizer_unit regression: pass");
        end else begin
            $display("modem_response_tokenizer_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mrt_pkg.sv
rtl/mrt_classify.sv
rtl/modem_response_tokenizer_unit.sv
bench/modem_response_tokenizer_unit_test.sv
